[hw/rtl/pwcc_pkg.sv]
// Package for the pulse width coin classifier: widths, register indexes,
// reset thresholds and the types shared by the top level and the digit pipeline.
// No dependencies.
`default_nettype none

package pwcc_pkg;

    // Width of the reported pulse width and of each threshold register.
    localparam int WIDTH_BITS = 16;
    // Default tick counter width.
    localparam int COUNT_BITS_DEF = 16;
    // Number of threshold registers.
    localparam int NUM_LIMITS = 5;
    // Configuration register index width.
    localparam int CFG_IDX_BITS = 3;
    // Class and digit widths.
    localparam int CLASS_BITS = 3;
    localparam int TTH_BITS = 3;
    localparam int DIGIT_BITS = 4;
    // Packed result: width, class, five digits, then zero padding to whole bytes.
    localparam int RESULT_BITS = WIDTH_BITS + CLASS_BITS + TTH_BITS + 4 * DIGIT_BITS;
    localparam int TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_BITS = 8;

    // Class code for a width at or above every threshold.
    localparam logic [CLASS_BITS-1:0] CLASS_ERROR = 3'd5;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_CLASS0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_CLASS4 = 3'd4;

    // Reciprocal constants: w / 100 = (w * RECIP_100_W) >> 23 for 16-bit w,
    // h / 100 = (h * 41) >> 12 for h up to 655, v / 10 = (v * 205) >> 11 for v below 100.
    localparam int RECIP_100_W = 83887;
    localparam int RECIP_100_W_SHIFT = 23;
    localparam int RECIP_100_H = 41;
    localparam int RECIP_100_H_SHIFT = 12;
    localparam int RECIP_10 = 205;
    localparam int RECIP_10_SHIFT = 11;

    typedef logic [WIDTH_BITS-1:0] t_limit;
    typedef t_limit [NUM_LIMITS-1:0] t_limits;

    localparam t_limits LIMIT_RESET = {16'd50000, 16'd40000, 16'd30000, 16'd20000, 16'd10000};

    // One item from the capture stage into the digit pipeline.
    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic                  done;
    } t_capture;

    // One result item.
    typedef struct packed {
        logic [DIGIT_BITS-1:0] units;
        logic [DIGIT_BITS-1:0] tens;
        logic [DIGIT_BITS-1:0] hundreds;
        logic [DIGIT_BITS-1:0] thousands;
        logic [TTH_BITS-1:0]   ten_thousands;
        logic [CLASS_BITS-1:0] coin_class;
        logic [WIDTH_BITS-1:0] width;
        logic                  done;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/pulse_width_coin_classifier.sv]
// Pulse width coin classifier: one item per tick in, one result item per tick out.
// A result passes the capture register and then three digit stages before it reaches
// the output. Throughput: one item per cycle unless the result side stalls; each stage
// stalls only when the next is full.
// Reset (synchronous, active low): counter stopped, waiting for a rising edge,
// width zero, thresholds 10000/20000/30000/40000/50000, pipeline empty.
`default_nettype none

module pulse_width_coin_classifier #(
    parameter int COUNT_BITS = pwcc_pkg::COUNT_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input item stream.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [pwcc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [0] pin_level, rest zero
    // Result item stream.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [15:0] pulse_width, [18:16] coin_class, [21:19] digit_ten_thousands,
    // [25:22] digit_thousands, [29:26] digit_hundreds, [33:30] digit_tens,
    // [37:34] digit_units, [39:38] zero
    output logic [pwcc_pkg::TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] capture_done
    // Configuration write channel.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [pwcc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [pwcc_pkg::WIDTH_BITS-1:0]     i_cfg_data
);

    localparam int WB = pwcc_pkg::WIDTH_BITS;
    localparam int EXT_BITS = (COUNT_BITS > WB) ? COUNT_BITS : WB;

    // Threshold registers, written whenever the channel is valid with an index of 0 to 4.
    pwcc_pkg::t_limits r_limits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= pwcc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && i_cfg_index <= pwcc_pkg::REG_LIMIT_CLASS4) begin
            r_limits[i_cfg_index] <= i_cfg_data;
        end
    end

    // Edge detection and tick counter, updated once per accepted item.
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_counting, n_counting;
    logic                  r_await, n_await;
    logic                  r_prev;
    logic [WB-1:0]         r_latched, n_latched;
    logic                  r_done, n_done;
    logic                  r_v1;
    logic                  level, rising, falling, accept, go1, dig_ready;
    logic [COUNT_BITS-1:0] count_inc;
    logic [EXT_BITS-1:0]   count_ext;

    assign go1           = !r_v1 || dig_ready;
    assign s_axis_tready = go1;
    assign accept        = s_axis_tvalid && go1;
    assign level         = s_axis_tdata[0];
    assign rising        = level && !r_prev;
    assign falling       = !level && r_prev;
    assign count_inc     = r_counting ? r_count + COUNT_BITS'(1) : r_count;
    assign count_ext     = EXT_BITS'(count_inc);

    always_comb begin
        n_count    = count_inc;
        n_counting = r_counting;
        n_await    = r_await;
        n_latched  = r_latched;
        n_done     = 1'b0;
        if (r_await) begin
            // Rising edge starts a new measurement.
            if (rising) begin
                n_count    = '0;
                n_counting = 1'b1;
                n_await    = 1'b0;
            end
        end else if (falling) begin
            // Falling edge stops the counter and latches the width.
            n_counting = 1'b0;
            n_latched  = count_ext[WB-1:0];
            n_await    = 1'b1;
            n_done     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_counting <= 1'b0;
            r_await    <= 1'b1;
            r_prev     <= 1'b0;
            r_latched  <= '0;
            r_done     <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            if (accept) begin
                r_count    <= n_count;
                r_counting <= n_counting;
                r_await    <= n_await;
                r_prev     <= level;
                r_latched  <= n_latched;
                r_done     <= n_done;
            end
            if (go1) begin
                r_v1 <= s_axis_tvalid;
            end
        end
    end

    // Class and digit pipeline.
    pwcc_pkg::t_capture capture;
    pwcc_pkg::t_result  result;

    assign capture.width = r_latched;
    assign capture.done  = r_done;

    pwcc_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .o_ready  (dig_ready),
        .i_item   (capture),
        .i_limits (r_limits),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack the result fields, highest field first, width in the lowest bits.
    assign m_axis_tdata = pwcc_pkg::TDATA_BITS'({result.units, result.tens, result.hundreds,
                                                  result.thousands, result.ten_thousands,
                                                  result.coin_class, result.width});
    assign m_axis_tuser = result.done;

endmodule

`default_nettype wire

[hw/rtl/pwcc_digits.sv]
// Classification and decimal digit pipeline of the pulse width coin classifier.
// Three registered stages with per-stage stall; depends on pwcc_pkg.
`default_nettype none

module pwcc_digits (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire pwcc_pkg::t_capture  i_item,
    input  wire pwcc_pkg::t_limits   i_limits,
    output logic                     o_valid,
    input  wire                      i_ready,
    output pwcc_pkg::t_result        o_result
);

    localparam int WB = pwcc_pkg::WIDTH_BITS;
    localparam int HI_BITS = 10;
    localparam int LO_BITS = 7;
    localparam int PROD_W_BITS = 33;
    localparam int PROD_H_BITS = 15;

    // Splits a value below 100 into its tens and units digits.
    function automatic logic [2*pwcc_pkg::DIGIT_BITS-1:0] split_tens(
        input logic [LO_BITS-1:0] v
    );
        logic [PROD_H_BITS-1:0]         p;
        logic [pwcc_pkg::DIGIT_BITS-1:0] t;
        logic [LO_BITS-1:0]             u;
        p = PROD_H_BITS'(v) * PROD_H_BITS'(pwcc_pkg::RECIP_10);
        t = p[pwcc_pkg::RECIP_10_SHIFT +: pwcc_pkg::DIGIT_BITS];
        u = v - ((LO_BITS'(t) << 3) + (LO_BITS'(t) << 1));
        return {t, u[pwcc_pkg::DIGIT_BITS-1:0]};
    endfunction

    // Stage valids and advance enables, last stage first.
    logic r_v2, r_v3, r_v4;
    logic go2, go3, go4;

    assign go4 = !r_v4 || i_ready;
    assign go3 = !r_v3 || go4;
    assign go2 = !r_v2 || go3;
    assign o_ready = go2;

    // Stage 2: class and width / 100.
    logic [WB-1:0]                   r2_width;
    logic                            r2_done;
    logic [pwcc_pkg::CLASS_BITS-1:0] r2_class;
    logic [HI_BITS-1:0]              r2_hi;
    logic [pwcc_pkg::CLASS_BITS-1:0] n_class;
    logic [PROD_W_BITS-1:0]          prod_w;

    always_comb begin
        n_class = pwcc_pkg::CLASS_ERROR;
        // First threshold that the width lies below sets the class.
        for (int k = pwcc_pkg::NUM_LIMITS - 1; k >= 0; k--) begin
            if (i_item.width < i_limits[k]) begin
                n_class = pwcc_pkg::CLASS_BITS'(k);
            end
        end
    end

    assign prod_w = PROD_W_BITS'(i_item.width) * PROD_W_BITS'(pwcc_pkg::RECIP_100_W);

    always_ff @(posedge i_clk) begin
        if (go2) begin
            r2_width <= i_item.width;
            r2_done  <= i_item.done;
            r2_class <= n_class;
            r2_hi    <= prod_w[pwcc_pkg::RECIP_100_W_SHIFT +: HI_BITS];
        end
    end

    // Stage 3: ten-thousands digit, hundreds pair and the last two digits.
    logic [PROD_H_BITS-1:0]          prod_h;
    logic [pwcc_pkg::TTH_BITS-1:0]   n_tth;
    logic [HI_BITS-1:0]              n_mid;
    logic [WB-1:0]                   n_low;
    logic [WB-1:0]                   r3_width;
    logic                            r3_done;
    logic [pwcc_pkg::CLASS_BITS-1:0] r3_class;
    logic [pwcc_pkg::TTH_BITS-1:0]   r3_tth;
    logic [LO_BITS-1:0]              r3_mid;
    logic [LO_BITS-1:0]              r3_low;

    assign prod_h = PROD_H_BITS'(r2_hi) * PROD_H_BITS'(pwcc_pkg::RECIP_100_H);
    assign n_tth  = prod_h[pwcc_pkg::RECIP_100_H_SHIFT +: pwcc_pkg::TTH_BITS];
    assign n_mid  = r2_hi - (HI_BITS'(n_tth) * HI_BITS'(100));
    assign n_low  = r2_width - (WB'(r2_hi) * WB'(100));

    always_ff @(posedge i_clk) begin
        if (go3) begin
            r3_width <= r2_width;
            r3_done  <= r2_done;
            r3_class <= r2_class;
            r3_tth   <= n_tth;
            r3_mid   <= n_mid[LO_BITS-1:0];
            r3_low   <= n_low[LO_BITS-1:0];
        end
    end

    // Stage 4: split both pairs into single digits; this is the output register.
    logic [2*pwcc_pkg::DIGIT_BITS-1:0] mid_pair;
    logic [2*pwcc_pkg::DIGIT_BITS-1:0] low_pair;
    pwcc_pkg::t_result                 r_result;

    assign mid_pair = split_tens(r3_mid);
    assign low_pair = split_tens(r3_low);

    always_ff @(posedge i_clk) begin
        if (go4) begin
            r_result.width         <= r3_width;
            r_result.done          <= r3_done;
            r_result.coin_class    <= r3_class;
            r_result.ten_thousands <= r3_tth;
            r_result.thousands     <= mid_pair[2*pwcc_pkg::DIGIT_BITS-1:pwcc_pkg::DIGIT_BITS];
            r_result.hundreds      <= mid_pair[pwcc_pkg::DIGIT_BITS-1:0];
            r_result.tens          <= low_pair[2*pwcc_pkg::DIGIT_BITS-1:pwcc_pkg::DIGIT_BITS];
            r_result.units         <= low_pair[pwcc_pkg::DIGIT_BITS-1:0];
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (go2) r_v2 <= i_valid;
            if (go3) r_v3 <= r_v2;
            if (go4) r_v4 <= r_v3;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r_result;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for pulse_width_coin_classifier: drives pin samples as items and
// checks every result item against a behavioural prediction of the classifier.
// Depends on pwcc_pkg and the pulse_width_coin_classifier RTL only.
`timescale 1ns / 100ps

module tb_top;

    // Run limit in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // Cycles to wait after the last result, beyond the four-stage pipeline.
    localparam int DRAIN_CYCLES = 8;
    // Least number of pin-sample items per random phase.
    localparam int unsigned PHASE_TICKS = 60;
    localparam int NUM_PHASES = 12;

    typedef logic [pwcc_pkg::WIDTH_BITS-1:0]   t_width;
    typedef logic [pwcc_pkg::CLASS_BITS-1:0]   t_class;
    typedef logic [pwcc_pkg::TTH_BITS-1:0]     t_tth;
    typedef logic [pwcc_pkg::DIGIT_BITS-1:0]   t_digit;
    typedef logic [pwcc_pkg::CFG_IDX_BITS-1:0] t_cfg_index;

    // One predicted result item, field by field.
    typedef struct {
        t_width width;
        t_class coin_class;
        logic   done;
        t_tth   ten_thousands;
        t_digit thousands;
        t_digit hundreds;
        t_digit tens;
        t_digit units;
    } t_coin_reading;

    // Tracks the capture state and thresholds, and checks the result items.
    class coin_scoreboard;
        pwcc_pkg::t_limits limits;
        t_width            tick_count;
        t_width            latched_width;
        logic              counting;
        logic              await_rising;
        logic              previous_level;
        t_coin_reading     pending_readings[$];
        int unsigned       mismatches;

        function new();
            limits         = pwcc_pkg::LIMIT_RESET;
            tick_count     = '0;
            latched_width  = '0;
            counting       = 1'b0;
            await_rising   = 1'b1;
            previous_level = 1'b0;
            mismatches     = 0;
        endfunction

        // Unknown register indexes are ignored by the block.
        function void write_register(t_cfg_index index, pwcc_pkg::t_limit value);
            if (index <= pwcc_pkg::REG_LIMIT_CLASS4)
                limits[index] = value;
        endfunction

        // The first threshold that the width lies below gives the class.
        function t_class coin_class_of(pwcc_pkg::t_limit w);
            for (int k = 0; k < pwcc_pkg::NUM_LIMITS; k++) begin
                if (w < limits[k])
                    return t_class'(k);
            end
            return pwcc_pkg::CLASS_ERROR;
        endfunction

        // Advances the capture state by one accepted pin sample.
        function void note_tick(logic pin);
            t_coin_reading r;
            logic          rising;
            logic          falling;
            rising  = pin && !previous_level;
            falling = !pin && previous_level;
            r.done  = 1'b0;
            if (counting)
                tick_count = tick_count + 1'b1;
            if (await_rising) begin
                if (rising) begin
                    tick_count   = '0;
                    counting     = 1'b1;
                    await_rising = 1'b0;
                end
            end else if (falling) begin
                counting      = 1'b0;
                latched_width = tick_count;
                await_rising  = 1'b1;
                r.done        = 1'b1;
            end
            previous_level  = pin;
            r.width         = latched_width;
            r.coin_class    = coin_class_of(latched_width);
            r.ten_thousands = t_tth'(latched_width / 10000);
            r.thousands     = t_digit'((latched_width / 1000) % 10);
            r.hundreds      = t_digit'((latched_width / 100) % 10);
            r.tens          = t_digit'((latched_width / 10) % 10);
            r.units         = t_digit'(latched_width % 10);
            pending_readings.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned expected, int unsigned actual);
            if (expected != actual) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
            end
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(logic [pwcc_pkg::TDATA_BITS-1:0] data, logic user);
            t_coin_reading r;
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected, tdata %h tuser %b",
                         $time, data, user);
                return;
            end
            r = pending_readings.pop_front();
            compare_field("pulse_width", 32'(r.width), 32'(data[15:0]));
            compare_field("coin_class", 32'(r.coin_class), 32'(data[18:16]));
            compare_field("digit_ten_thousands", 32'(r.ten_thousands), 32'(data[21:19]));
            compare_field("digit_thousands", 32'(r.thousands), 32'(data[25:22]));
            compare_field("digit_hundreds", 32'(r.hundreds), 32'(data[29:26]));
            compare_field("digit_tens", 32'(r.tens), 32'(data[33:30]));
            compare_field("digit_units", 32'(r.units), 32'(data[37:34]));
            compare_field("capture_done", 32'(r.done), 32'(user));
        endfunction

        function int unsigned pending();
            return pending_readings.size();
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [pwcc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [pwcc_pkg::TDATA_BITS-1:0]      m_axis_tdata;
    logic                                 m_axis_tuser;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    t_cfg_index                           i_cfg_index;
    logic [pwcc_pkg::WIDTH_BITS-1:0]      i_cfg_data;

    coin_scoreboard readings = new();
    bit             idle_on = 1'b1;
    int unsigned    ticks_sent = 0;
    int unsigned    cycle_count = 0;

    pulse_width_coin_classifier uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Gap length: mostly none, some short, a few long.
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Result side: random back-pressure.
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall == 0)
                stall = idle_gap();
            m_axis_tready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    // Every accepted result item is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            readings.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Sends one pin sample and waits for it to be accepted.
    task automatic send_tick(input logic pin);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pwcc_pkg::IN_TDATA_BITS-1){1'b0}}, pin};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        readings.note_tick(pin);
        ticks_sent++;
    endtask

    task automatic send_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
        repeat (high_ticks) send_tick(1'b1);
        repeat (low_ticks) send_tick(1'b0);
    endtask

    // Wider pulses run without idling to keep the run short.
    task automatic send_long_pulse(input int unsigned high_ticks);
        bit saved;
        saved   = idle_on;
        idle_on = 1'b0;
        send_pulse(high_ticks, 1);
        idle_on = saved;
    endtask

    // Stops sending and waits until the block has delivered everything.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (readings.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five thresholds, optionally followed by an unknown index.
    task automatic program_limits(input pwcc_pkg::t_limits lim, input bit with_unknown);
        t_cfg_index       index;
        pwcc_pkg::t_limit value;
        for (int k = 0; k <= pwcc_pkg::NUM_LIMITS; k++) begin
            if (k < pwcc_pkg::NUM_LIMITS || with_unknown) begin
                if (k < pwcc_pkg::NUM_LIMITS) begin
                    index = pwcc_pkg::REG_LIMIT_CLASS0 + t_cfg_index'(k);
                    value = lim[k];
                end else begin
                    index = pwcc_pkg::REG_LIMIT_CLASS4 + t_cfg_index'($urandom_range(1, 3));
                    value = pwcc_pkg::t_limit'($urandom);
                end
                i_cfg_valid <= 1'b1;
                i_cfg_index <= index;
                i_cfg_data  <= value;
                do
                    @(posedge i_clk);
                while (!o_cfg_ready);
                readings.write_register(index, value);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic pwcc_pkg::t_limits make_limits(
        input pwcc_pkg::t_limit l0, input pwcc_pkg::t_limit l1,
        input pwcc_pkg::t_limit l2, input pwcc_pkg::t_limit l3,
        input pwcc_pkg::t_limit l4
    );
        pwcc_pkg::t_limits lim;
        lim[0] = l0;
        lim[1] = l1;
        lim[2] = l2;
        lim[3] = l3;
        lim[4] = l4;
        return lim;
    endfunction

    // Threshold settings: small ascending, small unordered, extremes, or wide random.
    function automatic pwcc_pkg::t_limits random_limits();
        pwcc_pkg::t_limits lim;
        int unsigned       level;
        level = 0;
        case ($urandom_range(0, 5))
            0, 1: begin
                for (int k = 0; k < pwcc_pkg::NUM_LIMITS; k++) begin
                    level += $urandom_range(0, 12);
                    lim[k] = pwcc_pkg::t_limit'(level);
                end
            end
            2: begin
                for (int k = 0; k < pwcc_pkg::NUM_LIMITS; k++)
                    lim[k] = pwcc_pkg::t_limit'($urandom_range(0, 60));
            end
            3: lim = '0;
            4: lim = '1;
            default: begin
                for (int k = 0; k < pwcc_pkg::NUM_LIMITS; k++)
                    lim[k] = pwcc_pkg::t_limit'($urandom);
            end
        endcase
        return lim;
    endfunction

    // Mostly short pulses, now and then a wider one.
    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(1, 50);
        if (r < 98)
            return $urandom_range(51, 150);
        return $urandom_range(151, 400);
    endfunction

    // Main sequence.
    initial begin : stimulus
        int unsigned phase_start;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= pwcc_pkg::REG_LIMIT_CLASS0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: high pin on the first tick, a one-tick pulse
        // and a pulse with two digits.
        send_pulse(3, 2);
        send_pulse(1, 1);
        send_pulse(20, 1);
        settle();

        // Thresholds at maximum: a pulse wide enough for the hundreds digit.
        program_limits('1, 1'b0);
        send_long_pulse(259);
        settle();

        // Tight ascending thresholds give classes 1 to 4 and the error class, with an unknown index write.
        program_limits(make_limits(16'd1, 16'd2, 16'd3, 16'd4, 16'd5), 1'b1);
        for (int w = 1; w <= 6; w++)
            send_pulse(w, 1);
        settle();

        // All thresholds zero: everything is an error.
        program_limits('0, 1'b0);
        send_pulse(2, 1);
        settle();

        // Unordered thresholds are tested in index order.
        program_limits(make_limits(16'd30, 16'd10, 16'd20, 16'd5, 16'd40), 1'b0);
        send_pulse(4, 1);
        send_pulse(15, 1);
        send_pulse(35, 1);
        send_pulse(45, 2);
        settle();

        // Random phases, each under its own threshold setting.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            program_limits(random_limits(), $urandom_range(0, 3) == 0);
            idle_on     = ($urandom_range(0, 3) != 0);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
                end else begin
                    send_pulse(pick_width(), $urandom_range(1, 6));
                end
            end
            settle();
        end

        if (readings.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
